FILE: sv/lsbr_pkg.sv
// Package for the LSB-first bit reader.
// Holds the shared item type, field widths, result codes and default sizes.
// No dependencies.
`default_nettype none

package lsbr_pkg;

  // Fixed field widths of the transactions.
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned CODE_WIDTH_W = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CODE_W       = 16;

  // Bits appended by one byte push.
  localparam int unsigned BYTE_BITS = 8;

  // Default sizes handed down from the top level.
  localparam int unsigned ACC_BITS_DEF      = 32;
  localparam int unsigned MAX_CODE_BITS_DEF = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Opcodes of an input transaction.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_TAKEN = 2'd0,
    ST_FULL  = 2'd1,
    ST_CODE  = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  // A classified item as it waits in the queue.
  typedef struct packed {
    logic                    is_read;
    logic [DATA_W-1:0]       data_byte;
    logic [CODE_WIDTH_W-1:0] width;
  } item_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

FILE: sv/lsbr_front.sv
// Front of the LSB-first bit reader: accepts input transactions and classifies them.
// Depends on lsbr_pkg.
`default_nettype none

module lsbr_front
  import lsbr_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic                    push,
  output logic                    full,
  input  logic                    opcode,
  input  logic [DATA_W-1:0]       data_byte,
  input  logic [CODE_WIDTH_W-1:0] code_width,
  input  logic                    q_full,
  output logic                    q_wr,
  output item_t                   q_item
);

  localparam logic [CODE_WIDTH_W-1:0] MaxWidth = CODE_WIDTH_W'(MAX_CODE_BITS);

  // The input side is full whenever the queue cannot take another item.
  assign full = q_full;
  assign q_wr = push && !q_full;

  // Decode the opcode and saturate the requested width to the largest code size.
  always_comb begin
    q_item.is_read   = (opcode == OP_READ);
    q_item.data_byte = data_byte;
    q_item.width     = (code_width > MaxWidth) ? MaxWidth : code_width;
  end

endmodule

`default_nettype wire

FILE: sv/lsbr_queue.sv
// Short register queue between the front and the back of the bit reader.
// Depends on lsbr_pkg.
`default_nettype none

module lsbr_queue
  import lsbr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  item_t   wr_item,
  output logic    q_full,
  input  logic    rd,
  output q_head_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  item_t          entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign q_full     = (count == DepthCnt);
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthCnt)
    else $error("queue fill count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full && !rd |-> !wr)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> head.valid)
    else $error("read from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: sv/lsbr_back.sv
// Back of the LSB-first bit reader: holds the bit accumulator, carries out
// pushes and reads, and keeps the result register. Depends on lsbr_pkg.
`default_nettype none

module lsbr_back
  import lsbr_pkg::*;
#(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  q_head_t           head,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [STATUS_W-1:0] status,
  output logic [CODE_W-1:0] code_value
);

  localparam int unsigned HW = $clog2(ACC_BITS + 1);
  localparam logic [HW:0] AccBitsW = (HW + 1)'(ACC_BITS);
  localparam logic [HW:0] ByteBitsW = (HW + 1)'(BYTE_BITS);

  logic [ACC_BITS-1:0] acc;
  logic [ACC_BITS-1:0] acc_next;
  logic [HW-1:0]       held;
  logic [HW-1:0]       held_next;
  logic                out_valid;
  status_t             status_q;
  status_t             status_next;
  logic [CODE_W-1:0]   code_q;
  logic [CODE_W-1:0]   code_next;
  logic [CODE_W-1:0]   code_mask;
  logic [HW:0]         width_ext;
  logic                advance;

  // Take the next item when the result register is free or being emptied.
  assign advance = head.valid && (!out_valid || pop);
  assign q_rd    = advance;

  assign empty      = !out_valid;
  assign status     = status_q;
  assign code_value = code_q;

  assign width_ext = (HW + 1)'(head.item.width);

  // Mask that keeps the low bits of the code below the requested width.
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      code_mask[i] = (CODE_WIDTH_W'(i) < head.item.width);
    end
  end

  // Execute one push or read against the accumulator.
  always_comb begin
    acc_next    = acc;
    held_next   = held;
    status_next = ST_TAKEN;
    code_next   = '0;
    if (!head.item.is_read) begin
      if (({1'b0, held} + ByteBitsW) > AccBitsW) begin
        status_next = ST_FULL;
      end else begin
        acc_next    = acc | (ACC_BITS'(head.item.data_byte) << held);
        held_next   = held + HW'(BYTE_BITS);
        status_next = ST_TAKEN;
      end
    end else begin
      if ({1'b0, held} < width_ext) begin
        status_next = ST_SHORT;
      end else begin
        code_next   = acc[CODE_W-1:0] & code_mask;
        acc_next    = acc >> head.item.width;
        held_next   = held - HW'(head.item.width);
        status_next = ST_CODE;
      end
    end
  end

  // Accumulator state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        acc       <= acc_next;
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_q <= status_next;
      code_q   <= code_next;
    end
  end

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, held} <= AccBitsW)
    else $error("bit count exceeds the accumulator size");

  a_code_only_on_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status_q != ST_CODE) |-> (code_q == '0))
    else $error("code value not zero on a non-code result");

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (rst)
    advance && ((status_next == ST_FULL) || (status_next == ST_SHORT))
    |=> (held == $past(held)) && (acc == $past(acc)))
    else $error("refused transaction changed the accumulator");

  a_push_adds_byte: assert property (@(posedge clk) disable iff (rst)
    advance && (status_next == ST_TAKEN) |=> (held == $past(held) + HW'(BYTE_BITS)))
    else $error("taken byte did not add eight bits");
`endif

endmodule

`default_nettype wire

FILE: sv/lsb_first_bit_reader_top.sv
// Top level of the LSB-first variable-width bit reader.
// Depends on lsbr_pkg, lsbr_front, lsbr_queue and lsbr_back.
//
// Each transaction either pushes one byte above the bits already held, least
// significant bit first, or reads a code of 0 to MAX_CODE_BITS bits from the
// bottom of the accumulator; every transaction gives exactly one result with a
// status (byte taken, byte refused because the accumulator would overflow, code
// delivered, too few bits). A refused push or a short read changes nothing, and
// a width above MAX_CODE_BITS is treated as MAX_CODE_BITS. The block takes one
// transaction per cycle in sustained operation while results are popped; each
// result passes the queue and the result register. That rate is set by the
// back stage, which updates the accumulator and bit count once per cycle with a
// single shift and merge. A two-entry queue separates the input side from the
// back, so pushes are taken while a result waits, until the queue is full.
`default_nettype none

module lsb_first_bit_reader_top
  import lsbr_pkg::*;
#(
  parameter int unsigned ACC_BITS      = ACC_BITS_DEF,
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    opcode,
  input  logic [DATA_W-1:0]       data_byte,
  input  logic [CODE_WIDTH_W-1:0] code_width,
  output logic                    empty,
  input  logic                    pop,
  output logic [STATUS_W-1:0]     status,
  output logic [CODE_W-1:0]       code_value
);

  logic    q_full;
  logic    q_wr;
  logic    q_rd;
  item_t   q_item;
  q_head_t head;

  // Accept and classify incoming transactions.
  lsbr_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .data_byte (data_byte),
    .code_width(code_width),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (q_item)
  );

  // Queue between the front and the back.
  lsbr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_item(q_item),
    .q_full (q_full),
    .rd     (q_rd),
    .head   (head)
  );

  // Accumulator and result register.
  lsbr_back #(
    .ACC_BITS(ACC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_rd      (q_rd),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .code_value(code_value)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for lsb_first_bit_reader_top.
// Depends on lsbr_pkg and the RTL of the bit reader; it needs no other file.
// Directed and bursty random transactions are checked against a predictor.
module testbench;
  import lsbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Length of the receiver's long hold-off, in clock cycles.
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_ITEMS = 1850;

  // Patterns that the result side follows when popping.
  typedef enum int {POP_ALWAYS, POP_RANDOM, POP_SPARSE} pop_pattern_t;

  // One expected result as the block should present it.
  typedef struct {
    status_t           st;
    logic [CODE_W-1:0] code;
  } reader_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    opcode = OP_PUSH;
  logic [DATA_W-1:0]       data_byte = '0;
  logic [CODE_WIDTH_W-1:0] code_width = '0;
  logic                    pop = 1'b0;
  logic                    full;
  logic                    empty;
  logic [STATUS_W-1:0]     status;
  logic [CODE_W-1:0]       code_value;

  // Predictor state: the bits held and their count.
  logic [63:0]    bit_store = '0;
  int unsigned    stored_bits = 0;
  reader_result_t awaited_results[$];
  int             error_count = 0;
  bit             hold_req = 1'b0;
  int             burst_left = 0;

  lsb_first_bit_reader_top uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .code_width (code_width),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .code_value (code_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one accepted transaction and updates the held bits.
  function automatic reader_result_t next_reader_result(logic op, logic [DATA_W-1:0] b,
                                                        logic [CODE_WIDTH_W-1:0] w);
    reader_result_t r;
    int unsigned    eff_width;
    logic [63:0]    store_mask;
    logic [63:0]    code;
    r.code = '0;
    store_mask = ~64'd0 >> (64 - ACC_BITS_DEF);
    if (op == OP_PUSH) begin
      if (stored_bits + BYTE_BITS > ACC_BITS_DEF) begin
        r.st = ST_FULL;
      end else begin
        bit_store = (bit_store | (64'(b) << stored_bits)) & store_mask;
        stored_bits += BYTE_BITS;
        r.st = ST_TAKEN;
      end
    end else begin
      // Widths beyond the largest code size are clipped to it.
      eff_width = (w > MAX_CODE_BITS_DEF) ? MAX_CODE_BITS_DEF : w;
      if (stored_bits < eff_width) begin
        r.st = ST_SHORT;
      end else begin
        code = bit_store & ((64'd1 << eff_width) - 64'd1);
        bit_store = bit_store >> eff_width;
        stored_bits -= eff_width;
        r.st = ST_CODE;
        r.code = code[CODE_W-1:0];
      end
    end
    return r;
  endfunction

  // Predicts on every accepted input transaction and checks every popped result.
  always @(posedge clk) begin
    reader_result_t exp_r;
    if (!rst) begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d code_value 0x%04h", status, code_value);
          error_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (status !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, status);
            error_count++;
          end
          if (code_value !== exp_r.code) begin
            $error("code_value: expected 0x%04h, got 0x%04h", exp_r.code, code_value);
            error_count++;
          end
        end
      end
      if (push && !full)
        awaited_results.push_back(next_reader_result(opcode, data_byte, code_width));
    end
  end

  // Result side: pops on a changing pattern, with one long hold-off on request.
  initial begin
    pop_pattern_t pattern;
    int           phase_left;
    pattern = POP_ALWAYS;
    phase_left = 0;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (phase_left == 0) begin
        pattern = pop_pattern_t'($urandom_range(0, 2));
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      case (pattern)
        POP_ALWAYS: pop <= 1'b1;
        POP_RANDOM: pop <= ($urandom_range(0, 2) != 0);
        default:    pop <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk);
    end
  end

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send_item(logic op, logic [DATA_W-1:0] b, logic [CODE_WIDTH_W-1:0] w,
                           bit may_idle);
    int gap;
    if (may_idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    push       <= 1'b1;
    opcode     <= op;
    data_byte  <= b;
    code_width <= w;
    do @(posedge clk); while (full);
  endtask

  // Stops offering and waits until every expected result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Fills the accumulator to the top, then reads it out with zero, full and
  // oversized widths, ending with a read from an empty accumulator.
  task automatic test_fill_and_empty();
    send_item(OP_PUSH, 8'hFF, 5'd0, 1'b0);
    send_item(OP_PUSH, 8'h00, 5'd31, 1'b0);
    send_item(OP_PUSH, 8'hA5, 5'd0, 1'b0);
    send_item(OP_PUSH, 8'h5A, 5'd16, 1'b0);
    send_item(OP_PUSH, 8'h3C, 5'd0, 1'b0);
    send_item(OP_READ, 8'hFF, 5'd0, 1'b0);
    send_item(OP_READ, 8'h00, 5'd16, 1'b0);
    send_item(OP_READ, 8'hFF, 5'd31, 1'b0);
    send_item(OP_READ, 8'h00, 5'd1, 1'b0);
  endtask

  // Checks the overflow limit exactly and one bit over, then short reads.
  task automatic test_overflow_edge();
    send_item(OP_PUSH, 8'h81, 5'd0, 1'b0);
    send_item(OP_PUSH, 8'h7E, 5'd0, 1'b0);
    send_item(OP_PUSH, 8'hC3, 5'd0, 1'b0);
    send_item(OP_PUSH, 8'h96, 5'd0, 1'b0);
    send_item(OP_READ, 8'h00, 5'd7, 1'b0);
    send_item(OP_PUSH, 8'h11, 5'd0, 1'b0);
    send_item(OP_READ, 8'h00, 5'd1, 1'b0);
    send_item(OP_PUSH, 8'hEE, 5'd0, 1'b0);
    send_item(OP_READ, 8'h00, 5'd3, 1'b0);
    send_item(OP_READ, 8'h00, 5'd17, 1'b0);
    send_item(OP_READ, 8'h00, 5'd12, 1'b0);
    send_item(OP_READ, 8'h00, 5'd5, 1'b0);
    send_item(OP_READ, 8'h00, 5'd16, 1'b0);
  endtask

  // Random transaction with widths mostly in range, some zero and some oversized.
  task automatic send_random_item(int push_pct, bit may_idle);
    logic [CODE_WIDTH_W-1:0] w;
    int unsigned             pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      w = '0;
    else if (pick == 1)
      w = CODE_WIDTH_W'($urandom_range(MAX_CODE_BITS_DEF + 1, 31));
    else
      w = CODE_WIDTH_W'($urandom_range(1, MAX_CODE_BITS_DEF));
    send_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_READ,
              DATA_W'($urandom_range(0, 255)), w, may_idle);
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (30) send_random_item(50, 1'b0);
  endtask

  // Bursty random traffic in segments that lean towards filling or emptying.
  task automatic test_random_traffic();
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 30;
          1:       push_pct = 50;
          default: push_pct = 70;
        endcase
      end
      send_random_item(push_pct, 1'b1);
    end
  endtask

  // Main sequence: reset, then each test in turn.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_empty();
    drain_results();
    test_overflow_edge();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (error_count == 0)
      $display("lsb_first_bit_reader_top regression: pass");
    else
      $display("lsb_first_bit_reader_top regression: fail");
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #3000000;
    $display("lsb_first_bit_reader_top regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/lsbr_pkg.sv
sv/lsbr_front.sv
sv/lsbr_queue.sv
sv/lsbr_back.sv
sv/lsb_first_bit_reader_top.sv
tb/sv/testbench.sv
